// File: rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the magnetometer sample calibrator.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int NUM_AXES  = 3;
    localparam int RAW_W     = 16;
    localparam int ADJ_W     = 8;
    localparam int GAIN_W    = 9;
    localparam int OUT_W     = 23;
    localparam int Q_W       = 23;
    localparam int T_W       = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int REG_IDX_W = 2;
    localparam int PIPE_LEN  = 8;

    // Gain is (adj + 128) / 256; the milliGauss factor 49120/32760 reduces
    // to 1228/819, so the divisor is 819 * 256 with a round-half term.
    localparam logic [GAIN_W-1:0] ADJ_BIAS   = 9'd128;
    localparam int                MAG_NUM_W  = 11;
    localparam logic [10:0]       MAG_NUM    = 11'd1228;
    localparam logic [16:0]       ROUND_ADD  = 17'd104832;
    localparam int                DEN_SHIFT  = 8;
    localparam logic [9:0]        DIV_CONST  = 10'd819;
    localparam logic [22:0]       RECIP      = 23'd5244160;
    localparam int                RECIP_SHIFT = 32;
    localparam logic [T_W-1:0]    T_CLAMP    = 32'd3435135795;

    localparam logic [Q_W-1:0] POS_LIMIT = 23'h3FFFFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 23'h400000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 23'sh3FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 23'sh400000;

    localparam logic [REG_IDX_W-1:0] REG_SENS_ADJ_X  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SENS_ADJ_Y  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SENS_ADJ_Z  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CALIB_EN    = 2'd3;

    localparam logic [ADJ_W-1:0] SENS_ADJ_RESET = 8'd128;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [OUT_W-1:0] field_t;
    typedef logic [ADJ_W-1:0]        adj_t;

    typedef struct packed {
        logic advance;
        logic upd_minmax;
        logic upd_offset;
    } lane_ctrl_t;

endpackage

// File: rtl/msc_if.sv
// ----------------------------------------------------------------------------
// msc_if
// Valid/ready channels for raw sample items and calibrated field items.
// ----------------------------------------------------------------------------
interface msc_in_if;
    logic             valid;
    logic             ready;
    msc_pkg::raw_t    raw_x;
    msc_pkg::raw_t    raw_y;
    msc_pkg::raw_t    raw_z;
    logic             sensor_overflow;

    modport source (output valid, raw_x, raw_y, raw_z, sensor_overflow, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, sensor_overflow, output ready);
endinterface

interface msc_out_if;
    logic             valid;
    logic             ready;
    msc_pkg::field_t  field_x;
    msc_pkg::field_t  field_y;
    msc_pkg::field_t  field_z;
    logic             overflow_flag;

    modport source (output valid, field_x, field_y, field_z, overflow_flag, input ready);
    modport sink   (input valid, field_x, field_y, field_z, overflow_flag, output ready);
endinterface

// File: rtl/msc_cfg.sv
// ----------------------------------------------------------------------------
// msc_cfg
// APB register file holding the sensitivity bytes and the calibration enable.
// ----------------------------------------------------------------------------
module msc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msc_pkg::APB_AW-1:0]      paddr,
    input  logic [msc_pkg::APB_DW-1:0]      pwdata,
    output logic [msc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    output msc_pkg::adj_t [msc_pkg::NUM_AXES-1:0] sens_adj,
    output logic                            calib_en
);
    import msc_pkg::*;

    adj_t sens_x_reg, sens_y_reg, sens_z_reg;
    logic calib_en_reg;
    logic wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_x_reg   <= SENS_ADJ_RESET;
            sens_y_reg   <= SENS_ADJ_RESET;
            sens_z_reg   <= SENS_ADJ_RESET;
            calib_en_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SENS_ADJ_X: sens_x_reg   <= pwdata[ADJ_W-1:0];
                REG_SENS_ADJ_Y: sens_y_reg   <= pwdata[ADJ_W-1:0];
                REG_SENS_ADJ_Z: sens_z_reg   <= pwdata[ADJ_W-1:0];
                REG_CALIB_EN:   calib_en_reg <= pwdata[0];
                default:        calib_en_reg <= calib_en_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SENS_ADJ_X: prdata = APB_DW'(sens_x_reg);
            REG_SENS_ADJ_Y: prdata = APB_DW'(sens_y_reg);
            REG_SENS_ADJ_Z: prdata = APB_DW'(sens_z_reg);
            REG_CALIB_EN:   prdata = APB_DW'(calib_en_reg);
            default:        prdata = '0;
        endcase
    end

    assign sens_adj[0] = sens_x_reg;
    assign sens_adj[1] = sens_y_reg;
    assign sens_adj[2] = sens_z_reg;
    assign calib_en    = calib_en_reg;

endmodule

// File: rtl/msc_lane.sv
// ----------------------------------------------------------------------------
// msc_lane
// One axis: scaling pipeline with constant division, then min/max tracking,
// midpoint offset and offset removal.
// ----------------------------------------------------------------------------
module msc_lane #(
    parameter int RAW_BITS  = 16,
    parameter int FRAC_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msc_pkg::lane_ctrl_t   ctrl,
    input  msc_pkg::raw_t         raw,
    input  msc_pkg::adj_t         sens_adj,
    output msc_pkg::field_t       field
);
    import msc_pkg::*;

    localparam int P1_W  = RAW_BITS + GAIN_W;
    localparam int P2_W  = P1_W + MAG_NUM_W;
    localparam int SH_W  = P2_W + FRAC_BITS + 1;
    localparam int TF_W  = SH_W - DEN_SHIFT;
    localparam int CMP_W = (TF_W > T_W) ? TF_W : T_W;
    localparam int PR_W  = T_W + Q_W;

    logic [RAW_BITS-1:0] raw_bits;
    logic                neg;
    logic [RAW_BITS-1:0] mag;
    logic [GAIN_W-1:0]   gain;

    logic [P1_W-1:0]  p1_reg;
    logic [P2_W-1:0]  p2_reg;
    logic [T_W-1:0]   t3_reg, t4_reg;
    logic [Q_W-1:0]   qe4_reg, q5_reg;
    logic [5:1]       neg_reg;
    field_t           s6_reg, s7_reg, s8_reg;

    field_t max_reg, min_reg, offset_reg;
    field_t max_next, min_next;

    logic [SH_W-1:0]  shifted;
    logic [CMP_W-1:0] t_full;
    logic [T_W-1:0]   t3_next;
    logic [PR_W-1:0]  recip_prod;
    logic [T_W-1:0]   back_prod;
    logic [T_W-1:0]   remainder;
    logic [Q_W-1:0]   q5_next;
    field_t           s6_next;

    logic signed [OUT_W:0] mid_sum;
    logic signed [OUT_W:0] diff;

    assign raw_bits = raw[RAW_BITS-1:0];
    assign neg      = raw_bits[RAW_BITS-1];
    assign mag      = neg ? (~raw_bits + RAW_BITS'(1)) : raw_bits;
    assign gain     = GAIN_W'(sens_adj) + ADJ_BIAS;

    assign shifted = (SH_W'(p2_reg) << FRAC_BITS) + SH_W'(ROUND_ADD);
    assign t_full  = CMP_W'(shifted[SH_W-1:DEN_SHIFT]);
    assign t3_next = (t_full > CMP_W'(T_CLAMP)) ? T_CLAMP : t_full[T_W-1:0];

    assign recip_prod = PR_W'(t3_reg) * PR_W'(RECIP);

    assign back_prod = T_W'(qe4_reg) * T_W'(DIV_CONST);
    assign remainder = t4_reg - back_prod;
    assign q5_next   = (remainder >= T_W'(DIV_CONST)) ? (qe4_reg + Q_W'(1)) : qe4_reg;

    always_comb
    begin
        if (neg_reg[5])
        begin
            s6_next = (q5_reg > NEG_LIMIT) ? OUT_MIN : field_t'(~q5_reg + Q_W'(1));
        end
        else
        begin
            s6_next = (q5_reg > POS_LIMIT) ? OUT_MAX : field_t'(q5_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            p1_reg     <= P1_W'(mag) * P1_W'(gain);
            p2_reg     <= P2_W'(p1_reg) * P2_W'(MAG_NUM);
            t3_reg     <= t3_next;
            t4_reg     <= t3_reg;
            qe4_reg    <= recip_prod[RECIP_SHIFT +: Q_W];
            q5_reg     <= q5_next;
            neg_reg    <= {neg_reg[4:1], neg};
            s6_reg     <= s6_next;
            s7_reg     <= s6_reg;
            s8_reg     <= s7_reg;
        end
    end

    assign max_next = (s6_reg > max_reg) ? s6_reg : max_reg;
    assign min_next = (s6_reg < min_reg) ? s6_reg : min_reg;
    assign mid_sum  = {max_reg[OUT_W-1], max_reg} + {min_reg[OUT_W-1], min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= OUT_MIN;
            min_reg    <= OUT_MAX;
            offset_reg <= '0;
        end
        else
        begin
            if (ctrl.upd_minmax)
            begin
                max_reg <= max_next;
                min_reg <= min_next;
            end
            if (ctrl.upd_offset)
            begin
                offset_reg <= mid_sum[OUT_W:1];
            end
        end
    end

    assign diff = {s8_reg[OUT_W-1], s8_reg} - {offset_reg[OUT_W-1], offset_reg};

    always_comb
    begin
        if (diff[OUT_W] != diff[OUT_W-1])
        begin
            field = diff[OUT_W] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            field = diff[OUT_W-1:0];
        end
    end

endmodule

// File: rtl/msc_merge.sv
// ----------------------------------------------------------------------------
// msc_merge
// Output register that joins the three lane results and the overflow bit
// into one field item and paces the pipeline.
// ----------------------------------------------------------------------------
module msc_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_vld,
    input  logic                                    item_ovf,
    input  msc_pkg::field_t [msc_pkg::NUM_AXES-1:0] lane_field,
    msc_out_if.source                               field_out,
    output logic                                    advance
);
    import msc_pkg::*;

    logic   out_vld_reg, out_vld_next;
    field_t fx_reg, fy_reg, fz_reg;
    logic   ovf_reg;

    assign advance      = !out_vld_reg || field_out.ready;
    assign out_vld_next = advance ? item_vld : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_vld)
        begin
            fx_reg  <= lane_field[0];
            fy_reg  <= lane_field[1];
            fz_reg  <= lane_field[2];
            ovf_reg <= item_ovf;
        end
    end

    assign field_out.valid         = out_vld_reg;
    assign field_out.field_x       = fx_reg;
    assign field_out.field_y       = fy_reg;
    assign field_out.field_z       = fz_reg;
    assign field_out.overflow_flag = ovf_reg;

endmodule

// File: rtl/magnetometer_sample_calibrator_top.sv
// ----------------------------------------------------------------------------
// magnetometer_sample_calibrator_top
// Scales three-axis magnetometer samples to milliGauss and removes the
// hard-iron offset tracked from the running min/max of each axis.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock cycle while the output is not
// stalled and returns one field item per sample, in order. Three axis
// lanes work side by side through an eight-stage pipeline that holds the
// scaling multiplies, the division by the constant 819 and the min/max and
// offset updates; the output register then joins the lanes. The whole
// pipeline moves only while the output register is empty or being read, so
// a stalled output holds every item in place. The user must write registers
// through the APB port while no item is in flight; the block does not enforce it.
module magnetometer_sample_calibrator_top #(
    parameter int RAW_BITS  = 16,
    parameter int FRAC_BITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    msc_in_if.sink                      sample_in,
    msc_out_if.source                   field_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msc_pkg::APB_AW-1:0]  paddr,
    input  logic [msc_pkg::APB_DW-1:0]  pwdata,
    output logic [msc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import msc_pkg::*;

    adj_t [NUM_AXES-1:0]   sens_adj;
    logic                  calib_en;
    logic                  advance;
    lane_ctrl_t            lane_ctrl;
    raw_t [NUM_AXES-1:0]   raw;
    field_t [NUM_AXES-1:0] lane_field;

    logic [PIPE_LEN-1:0] vld_reg, vld_next;
    logic [PIPE_LEN-1:0] ovf_reg;

    msc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .sens_adj (sens_adj),
        .calib_en (calib_en)
    );

    assign sample_in.ready = advance;
    assign vld_next = advance ? {vld_reg[PIPE_LEN-2:0], sample_in.valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ovf_reg <= {ovf_reg[PIPE_LEN-2:0], sample_in.sensor_overflow};
        end
    end

    assign lane_ctrl.advance    = advance;
    assign lane_ctrl.upd_minmax = advance & vld_reg[PIPE_LEN-3] & calib_en;
    assign lane_ctrl.upd_offset = advance & vld_reg[PIPE_LEN-2] & calib_en;

    assign raw[0] = sample_in.raw_x;
    assign raw[1] = sample_in.raw_y;
    assign raw[2] = sample_in.raw_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        msc_lane #(
            .RAW_BITS  (RAW_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .raw      (raw[a]),
            .sens_adj (sens_adj[a]),
            .field    (lane_field[a])
        );
    end

    msc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_vld   (vld_reg[PIPE_LEN-1]),
        .item_ovf   (ovf_reg[PIPE_LEN-1]),
        .lane_field (lane_field),
        .field_out  (field_out),
        .advance    (advance)
    );

endmodule
